FILE: rtl/dsv_pkg.sv
// Package for the DSA signature check: state encoding and constants.
// No dependencies.
package dsv_pkg;
    localparam int unsigned DECODE_KEY = 1234;

    localparam logic [1:0] REG_P = 2'd0;
    localparam logic [1:0] REG_Q = 2'd1;
    localparam logic [1:0] REG_G = 2'd2;
    localparam logic [1:0] REG_Y = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INV_DIV,    // serial divide ra / rb
        ST_INV_UPD,    // t update, multiply tb*quo serially
        ST_INV_FIX,
        ST_U1,         // serial modmul digest*w mod q
        ST_U2,
        ST_RED_G,      // g mod p
        ST_RED_Y,
        ST_EXP_INIT,
        ST_EXP_MUL,    // acc*b mod p
        ST_EXP_SQR,    // b*b mod p
        ST_PROD,
        ST_VMOD,
        ST_OUT
    } dsv_state_t;
endpackage

FILE: rtl/dsv_modmul.sv
// Bit-serial modular multiplier (a*b mod m), MSB first, one bit of b per cycle.
// Uses dsv_pkg only by convention; operands must satisfy a < m when m > 0.
module dsv_modmul #(
    parameter int W = 31
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] res
);
    import dsv_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W+1:0]  dbl, dbl_r, add1, add1_r;

    always_comb begin
        // acc = 2*acc mod m, then + a mod m when the top bit of b is set; acc < m holds
        dbl   = {1'b0, acc_reg, 1'b0};
        dbl_r = (dbl >= {2'b0, m}) ? dbl - {2'b0, m} : dbl;
        add1  = dbl_r + (b_reg[W-1] ? {2'b0, a} : '0);
        add1_r = (add1 >= {2'b0, m}) ? add1 - {2'b0, m} : add1;
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            b_next    = b;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = add1_r[W-1:0];
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign res  = acc_reg;
endmodule

FILE: rtl/dsv_divider.sv
// Restoring serial divider: quotient and remainder of n / d, one bit per cycle.
// Used for Euclid steps and plain modulo reductions; d == 0 must not be started.
module dsv_divider #(
    parameter int W = 31
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] n,
    input  logic [W-1:0] d,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);
    import dsv_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb begin
        trial     = {r_reg, q_reg[W-1]};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = n;
            r_next    = '0;
            d_next    = d;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = W'(trial - {1'b0, d_reg});
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;
endmodule

FILE: rtl/dsa_signature_verify_unit.sv
// DSA signature check top level: config registers, sequencer, serial units.
// Depends on dsv_pkg, dsv_divider and dsv_modmul.
// Each item runs the Euclid steps, two modular exponentiations and six more serial
// operations one after another on the bit-serial units, so only one item is in
// flight: the input is accepted only in the idle state.
// The result waits in an output register, so the next item may start meanwhile.
// aresetn (sync, active low) loads p=2, q=2, g=1, y=1 and empties the pipeline.
module dsa_signature_verify_unit #(
    parameter int MOD_WIDTH = 31
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [MOD_WIDTH-1:0]         cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // digest, sig_r, sig_s from bit 0 up, zero filled to bytes
    input  logic [((3*MOD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // verified, no_inverse, check_value, decoded_message from bit 0 up
    output logic [((2*MOD_WIDTH+9)/8)*8-1:0] m_tdata
);
    import dsv_pkg::*;

    localparam int W   = MOD_WIDTH;
    localparam int SW  = W + 2;       // signed width for Euclid coefficients
    localparam int IW  = ((3*W+7)/8)*8;
    localparam int OW  = ((2*W+9)/8)*8;
    localparam int ECW = $clog2(W + 1);

    dsv_state_t state_reg, state_next;

    logic [W-1:0] p_reg, q_reg, g_reg, y_reg;
    logic [W-1:0] dig_reg, dig_next, r_reg, r_next;
    logic [W-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic signed [SW-1:0] ta_reg, ta_next, tb_reg, tb_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] w_reg, w_next, u1_reg, u1_next, u2_reg, u2_next;
    logic [W-1:0] gb_reg, gb_next, yb_reg, yb_next;
    logic [W-1:0] acc_reg, acc_next, base_reg, base_next, ex_reg, ex_next;
    logic [W-1:0] pa_reg, pa_next;
    logic [ECW-1:0] ebit_reg, ebit_next;
    logic         second_reg, second_next;
    logic         noinv_reg, noinv_next;
    logic [W-1:0] v_reg, v_next;
    logic         ovalid_reg, ovalid_next;
    logic [OW-1:0] odata_reg, odata_next;
    logic         ready_reg;

    // serial t update: tn = ta - tb*quo, shift-add over quo bits
    logic signed [SW-1:0] tm_reg, tm_next;
    logic [ECW-1:0] tcnt_reg, tcnt_next;

    logic         div_start, div_done, mul_start, mul_done;
    logic [W-1:0] div_n, div_d, div_q, div_r;
    logic [W-1:0] mul_a, mul_b, mul_m, mul_res;
    logic         mstart_reg, mstart_next, dstart_reg, dstart_next;

    dsv_divider #(.W(W)) u_div (
        .aclk, .aresetn, .start(div_start), .n(div_n), .d(div_d),
        .done(div_done), .quo(div_q), .rem(div_r)
    );

    dsv_modmul #(.W(W)) u_mul (
        .aclk, .aresetn, .start(mul_start), .a(mul_a), .b(mul_b), .m(mul_m),
        .done(mul_done), .res(mul_res)
    );

    assign div_start = dstart_reg;
    assign mul_start = mstart_reg;
    assign cfg_ready = 1'b1;
    assign s_tready  = ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= W'(2);
            q_reg <= W'(2);
            g_reg <= W'(1);
            y_reg <= W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_P:   p_reg <= cfg_data;
                REG_Q:   q_reg <= cfg_data;
                REG_G:   g_reg <= cfg_data;
                REG_Y:   y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // operand selection for the shared units
    always_comb begin
        div_n = ra_reg;
        div_d = rb_reg;
        mul_a = '0;
        mul_b = '0;
        mul_m = q_reg;
        case (state_reg)
            ST_RED_G:   begin div_n = g_reg;  div_d = p_reg; end
            ST_RED_Y:   begin div_n = y_reg;  div_d = p_reg; end
            ST_VMOD:    begin div_n = pa_reg; div_d = q_reg; end
            ST_U1:      begin mul_a = w_reg; mul_b = dig_reg; mul_m = q_reg; end
            ST_U2:      begin mul_a = w_reg; mul_b = r_reg;   mul_m = q_reg; end
            ST_EXP_MUL: begin mul_a = acc_reg; mul_b = base_reg; mul_m = p_reg; end
            ST_EXP_SQR: begin mul_a = base_reg; mul_b = base_reg; mul_m = p_reg; end
            ST_PROD:    begin mul_a = gb_reg; mul_b = yb_reg; mul_m = p_reg; end
            default:    ;
        endcase
    end

    logic signed [SW-1:0] tq_fix;

    always_comb begin
        state_next  = state_reg;
        dig_next    = dig_reg;
        r_next      = r_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        quo_next    = quo_reg;
        w_next      = w_reg;
        u1_next     = u1_reg;
        u2_next     = u2_reg;
        gb_next     = gb_reg;
        yb_next     = yb_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        ex_next     = ex_reg;
        pa_next     = pa_reg;
        ebit_next   = ebit_reg;
        second_next = second_reg;
        noinv_next  = noinv_reg;
        v_next      = v_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        tm_next     = tm_reg;
        tcnt_next   = tcnt_reg;
        mstart_next = 1'b0;
        dstart_next = 1'b0;
        tq_fix      = ta_reg + $signed({2'b0, q_reg});

        if (ovalid_reg && m_tready) ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    dig_next = s_tdata[W-1:0];
                    r_next   = s_tdata[2*W-1:W];
                    ra_next  = q_reg;
                    rb_next  = s_tdata[3*W-1:2*W];
                    ta_next  = '0;
                    tb_next  = SW'(1);
                    v_next   = '0;
                    if (q_reg == '0) begin
                        noinv_next = 1'b1;
                        state_next = ST_OUT;
                    end else if (s_tdata[3*W-1:2*W] == '0) begin
                        state_next = ST_INV_FIX;
                    end else begin
                        dstart_next = 1'b1;
                        state_next  = ST_INV_DIV;
                    end
                end
            end
            ST_INV_DIV: begin
                if (div_done) begin
                    quo_next  = div_q;
                    ra_next   = rb_reg;
                    rb_next   = div_r;
                    tm_next   = '0;
                    tcnt_next = ECW'(W);
                    state_next = ST_INV_UPD;
                end
            end
            ST_INV_UPD: begin
                // tm = tb * quo, MSB first
                tm_next = (tm_reg <<< 1) + (quo_reg[W-1] ? tb_reg : '0);
                quo_next = {quo_reg[W-2:0], 1'b0};
                tcnt_next = tcnt_reg - 1'b1;
                if (tcnt_reg == ECW'(1)) begin
                    ta_next = tb_reg;
                    tb_next = ta_reg - tm_next;
                    if (rb_reg == '0) begin
                        state_next = ST_INV_FIX;
                    end else begin
                        dstart_next = 1'b1;
                        state_next  = ST_INV_DIV;
                    end
                end
            end
            ST_INV_FIX: begin
                // |ta| <= q here, so one add covers the sign fix
                if (ra_reg != W'(1)) begin
                    noinv_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    noinv_next = 1'b0;
                    if (ta_reg < 0) w_next = tq_fix[W-1:0];
                    else if (ta_reg == $signed({2'b0, q_reg})) w_next = '0;
                    else w_next = ta_reg[W-1:0];
                    mstart_next = 1'b1;
                    state_next  = ST_U1;
                end
            end
            ST_U1: begin
                if (mul_done) begin
                    u1_next = mul_res;
                    mstart_next = 1'b1;
                    state_next  = ST_U2;
                end
            end
            ST_U2: begin
                if (mul_done) begin
                    u2_next = mul_res;
                    if (p_reg == '0) begin
                        pa_next = '0;
                        dstart_next = 1'b1;
                        state_next  = ST_VMOD;
                    end else begin
                        dstart_next = 1'b1;
                        state_next  = ST_RED_G;
                    end
                end
            end
            ST_RED_G: begin
                if (div_done) begin
                    gb_next = div_r;
                    dstart_next = 1'b1;
                    state_next  = ST_RED_Y;
                end
            end
            ST_RED_Y: begin
                if (div_done) begin
                    yb_next = div_r;
                    second_next = 1'b0;
                    state_next  = ST_EXP_INIT;
                end
            end
            ST_EXP_INIT: begin
                acc_next  = (p_reg == W'(1)) ? '0 : W'(1);
                base_next = second_reg ? yb_reg : gb_reg;
                ex_next   = second_reg ? u2_reg : u1_reg;
                ebit_next = ECW'(W);
                if ((second_reg ? u2_reg[0] : u1_reg[0])) begin
                    mstart_next = 1'b1;
                    state_next  = ST_EXP_MUL;
                end else begin
                    mstart_next = 1'b1;
                    state_next  = ST_EXP_SQR;
                end
            end
            ST_EXP_MUL: begin
                if (mul_done) begin
                    acc_next = mul_res;
                    mstart_next = 1'b1;
                    state_next  = ST_EXP_SQR;
                end
            end
            ST_EXP_SQR: begin
                if (mul_done) begin
                    base_next = mul_res;
                    ex_next   = ex_reg >> 1;
                    ebit_next = ebit_reg - 1'b1;
                    if (ebit_reg == ECW'(1)) begin
                        if (second_reg) begin
                            yb_next = acc_reg;
                            mstart_next = 1'b1;
                            state_next  = ST_PROD;
                        end else begin
                            gb_next = acc_reg;
                            second_next = 1'b1;
                            state_next  = ST_EXP_INIT;
                        end
                    end else begin
                        mstart_next = 1'b1;
                        state_next  = ex_reg[1] ? ST_EXP_MUL : ST_EXP_SQR;
                    end
                end
            end
            ST_PROD: begin
                if (mul_done) begin
                    pa_next = mul_res;
                    dstart_next = 1'b1;
                    state_next  = ST_VMOD;
                end
            end
            ST_VMOD: begin
                if (div_done) begin
                    v_next = div_r;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    odata_next  = OW'({dig_reg ^ W'(DECODE_KEY), v_reg, noinv_reg,
                                       (!noinv_reg && v_reg == r_reg)});
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            mstart_reg <= 1'b0;
            dstart_reg <= 1'b0;
            ready_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            mstart_reg <= mstart_next;
            dstart_reg <= dstart_next;
            ready_reg  <= (state_next == ST_IDLE);
        end
        dig_reg <= dig_next;   r_reg <= r_next;
        ra_reg <= ra_next;     rb_reg <= rb_next;
        ta_reg <= ta_next;     tb_reg <= tb_next;
        quo_reg <= quo_next;   w_reg <= w_next;
        u1_reg <= u1_next;     u2_reg <= u2_next;
        gb_reg <= gb_next;     yb_reg <= yb_next;
        acc_reg <= acc_next;   base_reg <= base_next;
        ex_reg <= ex_next;     pa_reg <= pa_next;
        ebit_reg <= ebit_next; second_reg <= second_next;
        noinv_reg <= noinv_next; v_reg <= v_next;
        tm_reg <= tm_next;     tcnt_reg <= tcnt_next;
        odata_reg <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");
    a_noinv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && odata_reg[1]) |-> odata_reg[W+1:2] == '0)
        else $error("check value nonzero without inverse");
    a_units_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mstart_reg && dstart_reg))
        else $error("both serial units started together");
`endif
endmodule

FILE: test/dsv_result_checker.sv
// Scoreboard for the DSA signature check: watches config, input and result channels,
// predicts each result, compares it with the whole result beat and prints each field on a mismatch.
// Depends on dsv_pkg for register indexes and the decode key.
module dsv_result_checker #(
    parameter int MOD_WIDTH = 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [MOD_WIDTH-1:0]              cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [((3*MOD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [((2*MOD_WIDTH+9)/8)*8-1:0]  m_tdata,
    output int                                fail_count,
    output int                                pending_count
);
    import dsv_pkg::*;

    typedef logic [MOD_WIDTH-1:0] val_t;

    typedef struct packed {
        val_t decoded_message;
        val_t check_value;
        logic no_inverse;
        logic verified;
    } verdict_t;

    val_t mod_p, ord_q, gen_g, key_y;
    verdict_t verdict_q[$];

    function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
                                                longint unsigned m);
        longint unsigned acc, b;
        acc = 1 % m;
        b = base % m;
        while (ex != 0) begin
            if (ex[0]) acc = (acc * b) % m;
            b = (b * b) % m;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic verdict_t predict_verdict(val_t digest, val_t sig_r, val_t sig_s);
        verdict_t vd;
        longint ra, rb, ta, tb, quo, rem, tn;
        longint unsigned w, u1, u2, prod, v;
        bit invertible;
        invertible = 0;
        w = 0;
        v = 0;
        if (ord_q != 0) begin
            ra = longint'(ord_q);
            rb = longint'(sig_s);
            ta = 0;
            tb = 1;
            while (rb != 0) begin
                quo = ra / rb;
                rem = ra % rb;
                tn = ta - tb * quo;
                ra = rb;
                rb = rem;
                ta = tb;
                tb = tn;
            end
            ta = ta % longint'(ord_q);
            if (ta < 0) ta = ta + longint'(ord_q);
            w = longint'(ta) % ord_q;
            invertible = (ra == 1);
        end
        if (invertible) begin
            u1 = (longint'(digest) * w) % ord_q;
            u2 = (longint'(sig_r) * w) % ord_q;
            prod = 0;
            if (mod_p != 0)
                prod = (pow_mod(gen_g, u1, mod_p) * pow_mod(key_y, u2, mod_p)) % mod_p;
            v = prod % ord_q;
        end
        vd.verified = invertible && (v == sig_r);
        vd.no_inverse = !invertible;
        vd.check_value = val_t'(v);
        vd.decoded_message = digest ^ val_t'(DECODE_KEY);
        return vd;
    endfunction

    assign pending_count = verdict_q.size();

    always @(posedge aclk) begin
        verdict_t got, want;
        if (!aresetn) begin
            mod_p <= val_t'(2);
            ord_q <= val_t'(2);
            gen_g <= val_t'(1);
            key_y <= val_t'(1);
            verdict_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_P: mod_p <= cfg_data;
                    REG_Q: ord_q <= cfg_data;
                    REG_G: gen_g <= cfg_data;
                    REG_Y: key_y <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                verdict_q.push_back(predict_verdict(s_tdata[MOD_WIDTH-1:0],
                    s_tdata[2*MOD_WIDTH-1:MOD_WIDTH], s_tdata[3*MOD_WIDTH-1:2*MOD_WIDTH]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[2*MOD_WIDTH+1:0];
                if (verdict_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result beat %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"ERROR: ver %0d/%0d noinv %0d/%0d v %0d/%0d",
                                      " dec %0d/%0d (exp/got)"},
                                want.verified, got.verified, want.no_inverse, got.no_inverse,
                                want.check_value, got.check_value,
                                want.decoded_message, got.decoded_message);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: test/dsa_signature_verify_unit_test.sv
// Top of the DSA signature check bench: clock, reset, stimulus and verdict.
// Depends on dsv_pkg, dsa_signature_verify_unit and dsv_result_checker.
module dsa_signature_verify_unit_test;
    import dsv_pkg::*;

    localparam int W = 31;
    localparam int HOLD_CYCLES = 12000;
    localparam int STALL_LIMIT = 50000;
    localparam longint unsigned VMAX = 64'h7fff_ffff;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_valid = 0;
    logic [1:0] cfg_index = REG_P;
    logic [W-1:0] cfg_data = '0;
    logic s_tvalid = 0;
    logic [95:0] s_tdata = '0;
    logic m_tready = 0;
    logic cfg_ready, s_tready, m_tvalid;
    logic [63:0] m_tdata;
    int fail_count, pending_count;

    int tx_idle = 0, rx_idle = 0;
    int hold_req = 0, hold_seen = 0, hold_left = 0;
    longint unsigned cur_p, cur_q, cur_g, cur_x;

    dsa_signature_verify_unit #(.MOD_WIDTH(W)) dut (.*);

    dsv_result_checker #(.MOD_WIDTH(W)) u_checker (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stalled = 0;
            else
                stalled++;
            if (stalled >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
                                                longint unsigned m);
        longint unsigned acc;
        acc = 1 % m;
        base = base % m;
        while (ex != 0) begin
            if (ex[0]) acc = (acc * base) % m;
            base = (base * base) % m;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    task automatic write_reg(logic [1:0] idx, longint unsigned val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= W'(val);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_item(longint unsigned digest, longint unsigned sig_r,
                             longint unsigned sig_s);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {3'b0, W'(sig_s), W'(sig_r), W'(digest)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic load_setup(longint unsigned p, longint unsigned q, longint unsigned g,
                              longint unsigned y);
        write_reg(REG_P, p);
        write_reg(REG_Q, q);
        write_reg(REG_G, g);
        write_reg(REG_Y, y);
    endtask

    // key pair over a subgroup of order q; h lifted to a generator
    task automatic new_key(longint unsigned p, longint unsigned q, longint unsigned h);
        cur_p = p;
        cur_q = q;
        cur_g = pow_mod(h, (p - 1) / q, p);
        cur_x = $urandom_range(int'(q - 1), 1);
        load_setup(p, q, cur_g, pow_mod(cur_g, cur_x, p));
    endtask

    task automatic send_signed(bit tamper);
        longint unsigned digest, k, r, s;
        digest = $urandom & VMAX;
        do begin
            k = $urandom_range(int'(cur_q - 1), 1);
            r = pow_mod(cur_g, k, cur_p) % cur_q;
            // k^-1 = k^(q-2) since q is prime
            s = (pow_mod(k, cur_q - 2, cur_q) * ((digest % cur_q + cur_x * r) % cur_q)) % cur_q;
        end while (r == 0 || s == 0);
        if (tamper) digest = digest ^ (64'd1 << $urandom_range(W - 1));
        send_item(digest, r, s);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 16 == 0) begin
                drain();
                if ($urandom_range(1)) new_key(23, 11, 2);
                else new_key(VMAX, 331, 7);
            end
            case ($urandom_range(9))
                0, 1: send_item($urandom & VMAX, $urandom & VMAX, $urandom & VMAX);
                2: send_signed(1);
                3: send_item($urandom & VMAX, $urandom_range(int'(cur_q)),
                             cur_q * $urandom_range(3));
                default: send_signed(0);
            endcase
        end
        drain();
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // reset setup: p=2, q=2, g=1, y=1
        send_item(0, 0, 0);
        send_item(VMAX, VMAX, VMAX);
        send_item(1234, 1, 1);
        send_item(5, 0, 1);
        drain();
        load_setup(VMAX, VMAX, VMAX, VMAX);
        send_item(VMAX, VMAX, VMAX);
        send_item(12345, 777, 65537);
        drain();
        write_reg(REG_Q, 0);
        send_item(99, 3, 5);
        drain();
        write_reg(REG_Q, 1);
        send_item(99, 0, 5);
        drain();
        load_setup(0, 11, 4, 18);
        send_item(42, 0, 3);
        drain();
        write_reg(REG_P, 1);
        send_item(42, 0, 3);
        drain();
        // operands above p, s a multiple of q, s zero
        load_setup(23, 11, 100, 5000);
        send_item(7, 30, 22);
        send_item(7, 30, 0);
        send_item(VMAX, VMAX, 13);
        drain();
        cur_p = 23; cur_q = 11; cur_g = 4; cur_x = 3;
        load_setup(23, 11, 4, 18);
        send_signed(0);
        send_signed(0);
        send_signed(1);
        drain();

        tx_idle = 14; rx_idle = 61;
        random_phase(42);
        tx_idle = 61; rx_idle = 14;
        random_phase(42);
        tx_idle = 0; rx_idle = 0;
        hold_req = hold_req + 1;
        random_phase(40);

        repeat (200) @(negedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: sim.f
rtl/dsv_pkg.sv
rtl/dsv_modmul.sv
rtl/dsv_divider.sv
rtl/dsa_signature_verify_unit.sv
test/dsv_result_checker.sv
test/dsa_signature_verify_unit_test.sv
